### design/wpg_pkg.sv
// Shared constants, table and register codes for the waypoint guidance block.
package wpg_pkg;

	localparam int POS_WIDTH_DEF     = 32;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// CORDIC datapath: positions are scaled to bit 60, plus gain growth and sign.
	localparam int SCALE_TOP = 60;
	localparam int CW        = 64;
	localparam int ZW        = 34;
	localparam int ATAN_LEN  = 24;

	// Arctangent of 2^-i in units of pi/2^31.
	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// 1/K of the CORDIC in Q30.
	localparam logic [29:0] INV_GAIN = 30'd652032874;

	// Surge fraction in Q12.
	localparam int            FRAC_W     = 13;
	localparam logic [12:0]   FRAC_ONE   = 13'd4096;
	localparam logic [12:0]   FRAC_FLOOR = 13'd1024;
	localparam logic [21:0]   DIST_CAP   = 22'd4096000;
	localparam logic [21:0]   PROD_CAP   = 22'd4097000;
	// floor(x/1000) = (x * RECIP_1000) >> RECIP_SH for x below 2^22.
	localparam logic [23:0]   RECIP_1000 = 24'd8589935;
	localparam int            RECIP_SH   = 33;

	localparam int SPEED_W = 18;
	localparam int GAIN_W  = 16;
	localparam int TOL_W   = 20;
	localparam int MODE_W  = 4;
	localparam int RANGE_W = 32;
	localparam int EN_W    = 3;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_ANGLE_ERROR = 3'd0,
		CFG_SURGE_GAIN      = 3'd1,
		CFG_MAX_SURGE       = 3'd2,
		CFG_TOL_NORTH       = 3'd3,
		CFG_TOL_EAST        = 3'd4,
		CFG_TOL_VERTICAL    = 3'd5
	} cfg_idx_t;

	localparam int RST_MAX_ANGLE_ERROR = 5461;
	localparam logic [GAIN_W-1:0] RST_SURGE_GAIN = 16'd410;
	localparam logic [GAIN_W-1:0] RST_MAX_SURGE  = 16'd500;
	localparam logic [TOL_W-1:0]  RST_TOL_NORTH  = 20'd1000;
	localparam logic [TOL_W-1:0]  RST_TOL_EAST   = 20'd1000;
	localparam logic [TOL_W-1:0]  RST_TOL_VERT   = 20'd500;

endpackage

### design/waypoint_goto_guidance_top.sv
// Top level of the line-of-sight waypoint guidance pipeline.
//
// Usage: one transfer on the s_ side carries a vehicle pose, a waypoint and a
// mode word; the m_ side returns one command transfer for it (surge, heading,
// depth-or-altitude set point, axis enables, arrival flag, range, marker end
// depth). Results leave in the order the poses came in.
// Throughput: one transfer per cycle while the m_ side accepts, no dependence between items.
// Pipeline: its depth is set by the CORDIC chain (one micro-rotation per
// stage), the range scaling multipliers and a 13-stage restoring divider
// for the heading-error scaling of surge.
// Handshake: each stage holds a valid bit and loads when it is empty or its
// content moves on, so bubbles close up and a stalled m_ side only blocks the
// input once every stage is full. A stall loses and repeats nothing.
// Reset (arst_n low): all valid bits clear, configuration registers return to defaults.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index;
// write only while no item is in flight.
module waypoint_goto_guidance_top #(
	parameter int POS_WIDTH     = wpg_pkg::POS_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = wpg_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = wpg_pkg::CORDIC_STAGES_DEF,
	localparam int IN_BITS  = 8*POS_WIDTH + 2*ANGLE_WIDTH + wpg_pkg::SPEED_W,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = wpg_pkg::SPEED_W + ANGLE_WIDTH + 2*POS_WIDTH + 1
	                          + wpg_pkg::RANGE_W,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// cfg write port
	input  logic                            cfg_wr_en,
	input  logic [wpg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wpg_pkg::CFG_W-1:0]       cfg_data,
	// pose / waypoint stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// low to high: cur_north, cur_east, cur_depth, cur_altitude, cur_heading,
	// goal_north, goal_east, goal_depth, goal_altitude, goal_heading, goal_speed
	input  logic [IN_W-1:0]                 s_tdata,
	// mode_flags
	input  logic [wpg_pkg::MODE_W-1:0]      s_tuser,
	// command stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// low to high: surge_cmd, heading_cmd, vertical_cmd, arrived,
	// range_to_goal, marker_end_z
	output logic [OUT_W-1:0]                m_tdata,
	// axis_enables
	output logic [wpg_pkg::EN_W-1:0]        m_tuser
);

	localparam int PW  = POS_WIDTH;
	localparam int AW  = ANGLE_WIDTH;
	localparam int CS  = CORDIC_STAGES;
	localparam int MW  = AW - 1;
	localparam int DW  = PW + 1;
	localparam int SH  = wpg_pkg::SCALE_TOP - PW;
	localparam int SHA = 32 - AW;
	localparam int CW  = wpg_pkg::CW;
	localparam int ZW  = wpg_pkg::ZW;
	localparam int QW  = wpg_pkg::FRAC_W;
	localparam int NUM_W = QW + MW;
	localparam int CMPW  = (DW > wpg_pkg::TOL_W) ? DW : wpg_pkg::TOL_W;

	// input field offsets
	localparam int O_CN = 0;
	localparam int O_CE = O_CN + PW;
	localparam int O_CD = O_CE + PW;
	localparam int O_CA = O_CD + PW;
	localparam int O_CH = O_CA + PW;
	localparam int O_GN = O_CH + AW;
	localparam int O_GE = O_GN + PW;
	localparam int O_GD = O_GE + PW;
	localparam int O_GA = O_GD + PW;
	localparam int O_GH = O_GA + PW;
	localparam int O_SP = O_GH + AW;

	// pipeline stage indexes
	localparam int P_S1   = 0;
	localparam int P_S2   = 1;
	localparam int P_MUL  = 2 + CS;
	localparam int P_DIST = P_MUL + 1;
	localparam int P_ERR  = P_MUL + 2;
	localparam int P_REC  = P_MUL + 3;
	localparam int P_Q    = P_MUL + 4;
	localparam int P_NUM  = P_MUL + 5;
	localparam int P_DIV0 = P_MUL + 6;
	localparam int P_PROD = P_DIV0 + QW;
	localparam int P_OUT  = P_PROD + 1;
	localparam int NST    = P_OUT + 1;

	typedef struct packed {
		logic                       hor;
		logic                       nz;
		logic                       ezero;
		logic                       arrived;
		logic [wpg_pkg::EN_W-1:0]   en;
		logic [AW-1:0]              heading;
		logic [AW-1:0]              ch;
		logic [wpg_pkg::SPEED_W-1:0] speed;
		logic [PW-1:0]              vcmd;
		logic [PW-1:0]              marker;
		logic [wpg_pkg::RANGE_W-1:0] range;
	} side_t;

	// ---------------- configuration registers ----------------
	logic [MW-1:0]              max_ae_q;
	logic [wpg_pkg::GAIN_W-1:0] gain_q;
	logic [wpg_pkg::GAIN_W-1:0] spd_lim_q;
	logic [wpg_pkg::TOL_W-1:0]  tol_n_q, tol_e_q, tol_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_ae_q    <= MW'(wpg_pkg::RST_MAX_ANGLE_ERROR);
			gain_q      <= wpg_pkg::RST_SURGE_GAIN;
			spd_lim_q   <= wpg_pkg::RST_MAX_SURGE;
			tol_n_q     <= wpg_pkg::RST_TOL_NORTH;
			tol_e_q     <= wpg_pkg::RST_TOL_EAST;
			tol_v_q     <= wpg_pkg::RST_TOL_VERT;
		end else if (cfg_wr_en) begin
			unique case (wpg_pkg::cfg_idx_t'(cfg_index))
				wpg_pkg::CFG_MAX_ANGLE_ERROR: max_ae_q    <= cfg_data[MW-1:0];
				wpg_pkg::CFG_SURGE_GAIN:      gain_q      <= cfg_data[wpg_pkg::GAIN_W-1:0];
				wpg_pkg::CFG_MAX_SURGE:       spd_lim_q   <= cfg_data[wpg_pkg::GAIN_W-1:0];
				wpg_pkg::CFG_TOL_NORTH:       tol_n_q     <= cfg_data[wpg_pkg::TOL_W-1:0];
				wpg_pkg::CFG_TOL_EAST:        tol_e_q     <= cfg_data[wpg_pkg::TOL_W-1:0];
				wpg_pkg::CFG_TOL_VERTICAL:    tol_v_q     <= cfg_data[wpg_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage valids and load enables ----------------
	// A stage loads when it is empty or its content is leaving this cycle.
	logic [NST-1:0] vld_q;
	logic [NST:0]   ld;

	always_comb begin
		ld[NST] = m_tready;
		for (int k = NST - 1; k >= 0; k--) begin
			ld[k] = ~vld_q[k] | ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) vld_q[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (ld[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_tready = ld[0];
	assign m_tvalid = vld_q[NST-1];

	// ---------------- stage 1: differences ----------------
	logic signed [PW-1:0] cn, ce, cd, ca, gn, ge, gd, ga;
	logic                 alt_in;

	assign cn = signed'(s_tdata[O_CN +: PW]);
	assign ce = signed'(s_tdata[O_CE +: PW]);
	assign cd = signed'(s_tdata[O_CD +: PW]);
	assign ca = signed'(s_tdata[O_CA +: PW]);
	assign gn = signed'(s_tdata[O_GN +: PW]);
	assign ge = signed'(s_tdata[O_GE +: PW]);
	assign gd = signed'(s_tdata[O_GD +: PW]);
	assign ga = signed'(s_tdata[O_GA +: PW]);
	assign alt_in = s_tuser[0];

	logic signed [DW-1:0] dn_s1, de_s1, vd_s1, mk_s1;
	logic signed [PW-1:0] cd_s1, gd_s1, dz_s1;
	logic [AW-1:0]        ch_s1, gh_s1;
	logic [wpg_pkg::SPEED_W-1:0] speed_s1;
	logic [wpg_pkg::MODE_W-1:0]  mode_s1;

	always_ff @(posedge clk) begin
		if (ld[P_S1]) begin
			dn_s1 <= {gn[PW-1], gn} - {cn[PW-1], cn};
			de_s1 <= {ge[PW-1], ge} - {ce[PW-1], ce};
			// current minus set point on the selected vertical axis
			vd_s1 <= alt_in ? ({ca[PW-1], ca} - {ga[PW-1], ga})
			                : ({cd[PW-1], cd} - {gd[PW-1], gd});
			mk_s1 <= {ca[PW-1], ca} - {ga[PW-1], ga};
			cd_s1 <= cd;
			gd_s1 <= gd;
			dz_s1 <= alt_in ? ga : gd;
			ch_s1 <= s_tdata[O_CH +: AW];
			gh_s1 <= s_tdata[O_GH +: AW];
			speed_s1 <= s_tdata[O_SP +: wpg_pkg::SPEED_W];
			mode_s1  <= s_tuser;
		end
	end

	// ---------------- stage 2: scale, pre-rotate, side results ----------------
	side_t side_q  [1:NST-1];
	side_t side_nx [1:NST-1];

	logic signed [CW-1:0] cx [0:CS];
	logic signed [CW-1:0] cy [0:CS];
	logic signed [ZW-1:0] cz [0:CS];

	logic signed [CW-1:0] xsc, ysc, x0, y0;
	logic signed [ZW-1:0] z0;
	logic [DW-1:0]        adn, ade, avd;
	logic signed [PW+1:0] mz;
	logic [PW-1:0]        mz_sat;
	logic                 hor2, ver2, yaw2, alt2, ok2;

	always_comb begin
		alt2 = mode_s1[0];
		hor2 = ~mode_s1[1];
		ver2 = ~mode_s1[2];
		yaw2 = ~mode_s1[3];

		xsc = {{(CW-DW){dn_s1[DW-1]}}, dn_s1} <<< SH;
		ysc = {{(CW-DW){de_s1[DW-1]}}, de_s1} <<< SH;
		x0 = xsc;
		y0 = ysc;
		z0 = '0;
		// bring the vector into the right half plane by a quarter turn
		if (dn_s1[DW-1]) begin
			if (!de_s1[DW-1]) begin
				x0 = ysc;
				y0 = -xsc;
				z0 = ZW'(1) <<< 30;
			end else begin
				x0 = -ysc;
				y0 = xsc;
				z0 = -(ZW'(1) <<< 30);
			end
		end

		adn = dn_s1[DW-1] ? DW'(-dn_s1) : DW'(dn_s1);
		ade = de_s1[DW-1] ? DW'(-de_s1) : DW'(de_s1);
		avd = vd_s1[DW-1] ? DW'(-vd_s1) : DW'(vd_s1);
		ok2 = 1'b1;
		if (hor2 && ((CMPW'(adn) > CMPW'(tol_n_q)) || (CMPW'(ade) > CMPW'(tol_e_q))))
			ok2 = 1'b0;
		if (ver2 && (CMPW'(avd) > CMPW'(tol_v_q)))
			ok2 = 1'b0;

		// marker end depth: current depth plus the altitude error in altitude mode, else goal depth
		mz = alt2 ? ({{2{cd_s1[PW-1]}}, cd_s1} + {mk_s1[DW-1], mk_s1})
		          : {{2{gd_s1[PW-1]}}, gd_s1};
		if ((mz[PW+1:PW-1] == 3'b000) || (mz[PW+1:PW-1] == 3'b111))
			mz_sat = mz[PW-1:0];
		else
			mz_sat = mz[PW+1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (ld[P_S2]) begin
			cx[0] <= x0;
			cy[0] <= y0;
			cz[0] <= z0;
		end
	end

	// ---------------- CORDIC chain ----------------
	for (genvar j = 0; j < CS; j++) begin : g_cordic
		wpg_cordic_stage #(.SHIFT(j)) u_stage (
			.clk   (clk),
			.ld    (ld[P_S2+1+j]),
			.x_in  (cx[j]),
			.y_in  (cy[j]),
			.z_in  (cz[j]),
			.x_out (cx[j+1]),
			.y_out (cy[j+1]),
			.z_out (cz[j+1])
		);
	end

	// ---------------- range scaling by 1/K ----------------
	logic [CW-2:0]  mag;
	logic [61:0]    lo_smul;
	logic [60:0]    hi_smul;
	logic signed [ZW-1:0] z_smul;

	assign mag = cx[CS][CW-1] ? '0 : cx[CS][CW-2:0];

	always_ff @(posedge clk) begin
		if (ld[P_MUL]) begin
			lo_smul <= mag[31:0] * wpg_pkg::INV_GAIN;
			hi_smul <= mag[CW-2:32] * wpg_pkg::INV_GAIN;
			z_smul  <= cz[CS];
		end
	end

	// ---------------- distance and bearing ----------------
	logic [65:0]    dsum;
	logic [62:0]    lo_rnd;
	logic [63:0]    dist_sdist;
	logic signed [ZW-1:0] zr;
	logic [AW-1:0]  bearing;

	always_comb begin
		lo_rnd = 63'(lo_smul) + (63'(1) << 29);
		dsum = 66'({hi_smul, 2'b00}) + 66'(lo_rnd[62:30]) + (66'(1) << (SH - 1));
		zr = z_smul + (ZW'(1) <<< (SHA - 1));
		bearing = side_q[P_MUL].nz ? zr[SHA +: AW] : '0;
	end

	always_ff @(posedge clk) begin
		if (ld[P_DIST]) begin
			dist_sdist <= side_q[P_MUL].nz ? 64'(dsum[65:SH]) : '0;
		end
	end

	// ---------------- heading error, gain product ----------------
	logic [AW-1:0]  err, eabs;
	logic           ezero;
	logic [21:0]    dmin;
	logic [37:0]    p_serr;
	logic [MW-1:0]  diff_serr;

	always_comb begin
		err  = side_q[P_DIST].heading - side_q[P_DIST].ch;
		eabs = err[AW-1] ? (-err) : err;
		ezero = (max_ae_q == '0) || (eabs >= {1'b0, max_ae_q});
		dmin = (dist_sdist > 64'(wpg_pkg::DIST_CAP)) ? wpg_pkg::DIST_CAP : dist_sdist[21:0];
	end

	always_ff @(posedge clk) begin
		if (ld[P_ERR]) begin
			p_serr    <= dmin * gain_q;
			diff_serr <= max_ae_q - eabs[MW-1:0];
		end
	end

	// ---------------- divide by 1000 ----------------
	logic [21:0] pc;
	logic [45:0] rec_srec;
	logic [12:0] qq;
	logic [QW-1:0] q_sq;

	assign pc = (p_serr > 38'(wpg_pkg::PROD_CAP)) ? wpg_pkg::PROD_CAP : p_serr[21:0];
	assign qq = rec_srec[wpg_pkg::RECIP_SH +: 13];

	always_ff @(posedge clk) begin
		if (ld[P_REC]) rec_srec <= pc * wpg_pkg::RECIP_1000;
		if (ld[P_Q])   q_sq <= (qq > wpg_pkg::FRAC_ONE) ? wpg_pkg::FRAC_ONE : qq;
	end

	// ---------------- fraction scaled by remaining error margin ----------------
	logic [NUM_W-1:0] dr [0:QW];
	logic [QW-1:0]    dq [0:QW];
	logic [MW-1:0]    diff_sq;

	always_ff @(posedge clk) begin
		if (ld[P_REC]) diff_sq <= diff_serr;
	end

	logic [MW-1:0] diff_srec;
	always_ff @(posedge clk) begin
		if (ld[P_Q]) diff_srec <= diff_sq;
	end

	always_ff @(posedge clk) begin
		if (ld[P_NUM]) begin
			dr[0] <= q_sq * diff_srec;
			dq[0] <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		wpg_div_stage #(
			.NUM_W (NUM_W),
			.DEN_W (MW),
			.QW    (QW),
			.BIT   (QW - 1 - j)
		) u_div (
			.clk     (clk),
			.ld      (ld[P_DIV0+j]),
			.rem_in  (dr[j]),
			.quo_in  (dq[j]),
			.den     (max_ae_q),
			.rem_out (dr[j+1]),
			.quo_out (dq[j+1])
		);
	end

	// ---------------- floor, speed select, product ----------------
	logic [QW-1:0] s_frac;
	logic [wpg_pkg::SPEED_W-1:0] tri_max, spd;
	logic [QW+wpg_pkg::SPEED_W-1:0] prod_sprod;

	always_comb begin
		s_frac = side_q[P_PROD-1].ezero ? '0 : dq[QW];
		if ((s_frac != '0) && (s_frac < wpg_pkg::FRAC_FLOOR))
			s_frac = wpg_pkg::FRAC_FLOOR;
		tri_max = {1'b0, spd_lim_q, 1'b0} + {2'b00, spd_lim_q};
		if ((side_q[P_PROD-1].speed == '0) || (side_q[P_PROD-1].speed > tri_max))
			spd = {2'b00, spd_lim_q};
		else
			spd = side_q[P_PROD-1].speed;
	end

	always_ff @(posedge clk) begin
		if (ld[P_PROD]) prod_sprod <= s_frac * spd;
	end

	// ---------------- output register ----------------
	logic [QW+wpg_pkg::SPEED_W:0]  surge_rnd;
	logic [wpg_pkg::SPEED_W-1:0]   surge_sout;

	assign surge_rnd = {1'b0, prod_sprod} + (QW+wpg_pkg::SPEED_W+1)'(2048);

	always_ff @(posedge clk) begin
		if (ld[P_OUT])
			surge_sout <= side_q[P_PROD].hor ? surge_rnd[12 +: wpg_pkg::SPEED_W] : '0;
	end

	// ---------------- side fields travelling with the item ----------------
	always_comb begin
		for (int k = 2; k < NST; k++) begin
			side_nx[k] = side_q[k-1];
		end
		side_nx[1].hor     = hor2;
		side_nx[1].nz      = (dn_s1 != '0) || (de_s1 != '0);
		side_nx[1].ezero   = 1'b0;
		side_nx[1].arrived = ok2;
		side_nx[1].en      = {hor2 | yaw2, hor2, ver2};
		side_nx[1].heading = yaw2 ? gh_s1 : '0;
		side_nx[1].ch      = ch_s1;
		side_nx[1].speed   = speed_s1;
		side_nx[1].vcmd    = ver2 ? dz_s1 : '0;
		side_nx[1].marker  = mz_sat;
		side_nx[1].range   = '0;
		// commanded heading becomes the bearing when horizontal motion is on
		if (side_q[P_MUL].hor)
			side_nx[P_DIST].heading = bearing;
		side_nx[P_ERR].range = (dist_sdist[63:32] != '0) ? '1 : dist_sdist[31:0];
		side_nx[P_ERR].ezero = ezero;
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k < NST; k++) begin
			if (ld[k]) side_q[k] <= side_nx[k];
		end
	end

	assign m_tdata = OUT_W'({side_q[P_OUT].marker, side_q[P_OUT].range,
	                         side_q[P_OUT].arrived, side_q[P_OUT].vcmd,
	                         side_q[P_OUT].heading, surge_sout});
	assign m_tuser = side_q[P_OUT].en;

endmodule

### design/wpg_cordic_stage.sv
// One registered vectoring CORDIC micro-rotation.
module wpg_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  logic                            clk,
	input  logic                            ld,
	input  logic signed [wpg_pkg::CW-1:0]   x_in,
	input  logic signed [wpg_pkg::CW-1:0]   y_in,
	input  logic signed [wpg_pkg::ZW-1:0]   z_in,
	output logic signed [wpg_pkg::CW-1:0]   x_out,
	output logic signed [wpg_pkg::CW-1:0]   y_out,
	output logic signed [wpg_pkg::ZW-1:0]   z_out
);

	logic signed [wpg_pkg::CW-1:0] xs, ys, x_nx, y_nx;
	logic signed [wpg_pkg::ZW-1:0] step, z_nx;

	always_comb begin
		xs   = x_in >>> SHIFT;
		ys   = y_in >>> SHIFT;
		step = signed'({{(wpg_pkg::ZW-32){1'b0}}, wpg_pkg::ATAN_TAB[SHIFT]});
		if (!y_in[wpg_pkg::CW-1]) begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + step;
		end else begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - step;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			x_out <= x_nx;
			y_out <= y_nx;
			z_out <= z_nx;
		end
	end

endmodule

### design/wpg_div_stage.sv
// One registered bit of a restoring divider.
module wpg_div_stage #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 15,
	parameter int QW    = 13,
	parameter int BIT   = 0
) (
	input  logic             clk,
	input  logic             ld,
	input  logic [NUM_W-1:0] rem_in,
	input  logic [QW-1:0]    quo_in,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] rem_out,
	output logic [QW-1:0]    quo_out
);

	logic [NUM_W-1:0] dshift;
	logic             fits;

	always_comb begin
		dshift = NUM_W'(den) << BIT;
		fits   = rem_in >= dshift;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rem_out <= fits ? (rem_in - dshift) : rem_in;
			quo_out <= quo_in | (fits ? (QW'(1) << BIT) : QW'(0));
		end
	end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the waypoint guidance pipeline: directed and random poses.
`timescale 1ns / 100ps

module tb_top;

	localparam int IN_W      = 312;
	localparam int OUT_W     = 136;
	localparam int LIMIT     = 400000;
	localparam int N_STAGES  = wpg_pkg::CORDIC_STAGES_DEF;
	localparam int LATENCY   = N_STAGES + 23;

	// arctangent of 2^-i, units of pi/2^31
	localparam longint BEARING_STEP [16] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};

	typedef struct {
		logic signed [31:0] cn, ce, cd, ca;
		logic [15:0]        ch;
		logic signed [31:0] gn, ge, gd, ga;
		logic [15:0]        gh;
		logic [17:0]        spd;
		logic [3:0]         mode;
	} pose_t;

	typedef struct {
		logic [17:0] surge;
		logic [15:0] hdg;
		logic [31:0] vert;
		logic [2:0]  en;
		logic        arr;
		logic [31:0] range;
		logic [31:0] mz;
	} cmd_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [19:0]       cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic [3:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic [2:0]        m_tuser;

	// local copy of the register file
	longint mae = wpg_pkg::RST_MAX_ANGLE_ERROR, gain = 410, surge_lim = 500;
	longint tol_n = 1000, tol_e = 1000, tol_v = 500;

	cmd_t   pending_cmds[$];
	int     errors = 0;
	int     n_sent = 0, n_seen = 0, n_arrived = 0;
	int     cycles = 0;
	bit     steady = 1'b0;   // no idling on either side while set

	always #2 clk = ~clk;

	waypoint_goto_guidance_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Bit-exact command prediction for one pose.
	function automatic cmd_t predict_command(pose_t p);
		cmd_t   c;
		longint dn, de, x, y, z, t, xs, ys, dz, curz, mz;
		longint unsigned mag, lo, hi, m, dist_mm, bearing, range, err, eabs, q, s, spd, surge;
		bit     alt, hor, ver, yaw, ok;
		dn = longint'(p.gn) - longint'(p.cn);
		de = longint'(p.ge) - longint'(p.ce);
		bearing = 0;
		dist_mm = 0;
		if (dn != 0 || de != 0) begin
			x = dn <<< 28;
			y = de <<< 28;
			z = 0;
			// fold the left half plane in by a quarter turn
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; z = 1073741824;
				end else begin
					x = -y; y = t; z = -1073741824;
				end
			end
			for (int i = 0; i < N_STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + BEARING_STEP[i];
				end else begin
					x = x - ys; y = y + xs; z = z - BEARING_STEP[i];
				end
			end
			mag = (x < 0) ? 0 : x;
			lo = (mag & 64'hFFFF_FFFF) * 64'd652032874;
			hi = (mag >> 32) * 64'd652032874;
			m = (hi << 2) + ((lo + (64'd1 << 29)) >> 30);
			dist_mm = (m + (64'd1 << 27)) >> 28;
			z = (z + 32768) >>> 16;
			bearing = z & 64'hFFFF;
		end
		range = (dist_mm > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : dist_mm;
		err = (bearing - p.ch) & 64'hFFFF;
		eabs = err[15] ? 64'd65536 - err : err;
		q = (((dist_mm > 4096000) ? 64'd4096000 : dist_mm) * gain) / 1000;
		if (q > 4096) q = 4096;
		s = 0;
		if (mae != 0 && eabs < mae) s = (q * (mae - eabs)) / mae;
		if (s > 0 && s < 1024) s = 1024;
		spd = 64'(p.spd);
		if (spd == 0 || spd > 3 * surge_lim) spd = surge_lim;
		surge = (s * spd + 2048) >> 12;

		alt = p.mode[0];
		hor = !p.mode[1];
		ver = !p.mode[2];
		yaw = !p.mode[3];
		dz = alt ? longint'(p.ga) : longint'(p.gd);
		curz = alt ? longint'(p.ca) : longint'(p.cd);
		ok = 1'b1;
		if (hor && (absval(longint'(p.cn) - p.gn) > tol_n ||
		            absval(longint'(p.ce) - p.ge) > tol_e))
			ok = 1'b0;
		if (ver && absval(curz - dz) > tol_v) ok = 1'b0;

		c.hdg = '0;
		c.en = '0;
		if (ver) c.en[0] = 1'b1;
		if (hor) begin
			c.en[2:1] = 2'b11;
			c.hdg = bearing[15:0];
		end else if (yaw) begin
			c.en[2] = 1'b1;
			c.hdg = p.gh;
		end
		mz = alt ? longint'(p.cd) + (longint'(p.ca) - p.ga) : longint'(p.gd);
		if (mz > 64'sd2147483647) mz = 64'sd2147483647;
		if (mz < -64'sd2147483648) mz = -64'sd2147483648;

		c.surge = hor ? surge[17:0] : '0;
		c.vert  = ver ? dz[31:0] : '0;
		c.arr   = ok;
		c.range = range[31:0];
		c.mz    = mz[31:0];
		return c;
	endfunction

	function automatic bit want_idle();
		return !steady && ($urandom_range(99) < 28);
	endfunction

	// One pose transfer; the model is run at the accepting edge.
	task automatic send_pose(pose_t p);
		while (want_idle()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, p.spd, p.gh, p.ga, p.gd, p.ge, p.gn, p.ch, p.ca, p.cd, p.ce, p.cn};
		s_tuser  <= p.mode;
		do @(posedge clk); while (!s_tready);
		pending_cmds = {pending_cmds, predict_command(p)};
		n_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(wpg_pkg::cfg_idx_t idx, logic [19:0] v);
		case (idx)
			wpg_pkg::CFG_MAX_ANGLE_ERROR: mae       = longint'(v & 20'h7FFF);
			wpg_pkg::CFG_SURGE_GAIN:      gain      = longint'(v & 20'hFFFF);
			wpg_pkg::CFG_MAX_SURGE:       surge_lim = longint'(v & 20'hFFFF);
			wpg_pkg::CFG_TOL_NORTH:       tol_n     = longint'(v);
			wpg_pkg::CFG_TOL_EAST:        tol_e     = longint'(v);
			wpg_pkg::CFG_TOL_VERTICAL:    tol_v     = longint'(v);
			default: ;
		endcase
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_all(logic [19:0] a, logic [19:0] g, logic [19:0] ms,
	                       logic [19:0] tn, logic [19:0] te, logic [19:0] tv);
		wait_idle();
		set_reg(wpg_pkg::CFG_MAX_ANGLE_ERROR, a);
		set_reg(wpg_pkg::CFG_SURGE_GAIN, g);
		set_reg(wpg_pkg::CFG_MAX_SURGE, ms);
		set_reg(wpg_pkg::CFG_TOL_NORTH, tn);
		set_reg(wpg_pkg::CFG_TOL_EAST, te);
		set_reg(wpg_pkg::CFG_TOL_VERTICAL, tv);
	endtask

	function automatic logic [31:0] near(logic [31:0] base, int span);
		return base + $urandom_range(2 * span) - span;
	endfunction

	// Mostly poses close to the goal or at moderate offsets, some pure noise.
	function automatic pose_t random_pose();
		pose_t p;
		int    kind, span;
		kind = $urandom_range(9);
		p.gn = $urandom; p.ge = $urandom; p.gd = $urandom; p.ga = $urandom;
		p.gh = 16'($urandom); p.ch = 16'($urandom);
		p.mode = 4'($urandom);
		case ($urandom_range(3))
			0: p.spd = 0;
			1: p.spd = 18'($urandom_range(2000));
			default: p.spd = 18'($urandom);
		endcase
		if (kind < 4) begin
			span = int'(2 * (tol_n > 1000 ? 1000 : tol_n + 2));
			p.cn = near(p.gn, span);
			p.ce = near(p.ge, span);
			p.cd = near(p.gd, span);
			p.ca = near(p.ga, span);
		end else if (kind < 7) begin
			p.cn = near(p.gn, 1 << $urandom_range(20));
			p.ce = near(p.ge, 1 << $urandom_range(20));
			p.cd = $urandom; p.ca = $urandom;
		end else begin
			p.cn = $urandom; p.ce = $urandom; p.cd = $urandom; p.ca = $urandom;
		end
		return p;
	endfunction

	// Result checker and sink-side stalls.
	always @(posedge clk) begin
		cmd_t   want, got;
		longint w[7], g[7];
		string  names[7];
		if (m_tvalid && m_tready) begin
			got.surge = m_tdata[17:0];
			got.hdg   = m_tdata[33:18];
			got.vert  = m_tdata[65:34];
			got.arr   = m_tdata[66];
			got.range = m_tdata[98:67];
			got.mz    = m_tdata[130:99];
			got.en    = m_tuser;
			n_seen++;
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command transfer", $time);
				errors++;
			end else begin
				want = pending_cmds.pop_front();
				if (got.arr) n_arrived++;
				names = '{"surge", "heading", "vertical", "enables", "arrived", "range",
				          "marker_z"};
				w = '{want.surge, want.hdg, want.vert, want.en, want.arr, want.range, want.mz};
				g = '{got.surge, got.hdg, got.vert, got.en, got.arr, got.range, got.mz};
				for (int i = 0; i < 7; i++)
					if (w[i] != g[i]) begin
						$display("%0t: %s mismatch, expected %h, actual %h",
						         $time, names[i], w[i], g[i]);
						errors++;
					end
			end
		end
		m_tready <= arst_n && !want_idle();
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Corner poses; each also carries a mode word, mostly the low four bits of its index.
	task automatic test_directed();
		pose_t p, z;
		z = '{default: '0};
		for (int i = 0; i < 22; i++) begin
			p = z;
			p.mode = i[3:0];
			p.gh = 16'h7FFF;
			case (i)
				0: ;                                   // goal on top of vehicle
				1: p.gn = 1000;                        // right on the tolerance
				2: p.gn = 1001;
				3: p.ge = -1000;
				4: begin p.cn = 32'h8000_0000; p.gn = 32'h7FFF_FFFF;
				         p.ce = 32'h8000_0000; p.ge = 32'h7FFF_FFFF; p.spd = '1; end
				5: begin p.gn = -5000; p.ge = 3000; end
				6: begin p.gn = -5000; p.ge = -3000; p.ch = 16'h8000; end
				7: begin p.gn = 20000; p.ch = 16'd5461; end   // error at the limit
				8: begin p.gn = 20000; p.ch = 16'd5460; end
				9: begin p.gn = 20000; p.ch = 16'h8000; end
				10: begin p.gn = 900; p.spd = 1501; end
				11: begin p.gn = 900; p.spd = 1500; end
				12: begin p.gn = 30000; p.spd = '1; end
				13: begin p.cd = 32'h7FFF_FFFF; p.ca = 32'h7FFF_FFFF; p.ga = 32'h8000_0000; end
				14: begin p.cd = 32'h8000_0000; p.ca = 32'h8000_0000; p.ga = 32'h7FFF_FFFF;
				          p.gd = 32'h8000_0000; end
				15: begin p.gd = 500; p.ga = 501; p.ch = 16'h7FFF; end
				16: begin p.mode = 4'd1; p.ga = 501; end
				17: begin p.gn = -1; p.ge = 0; end
				18: begin p.gn = 0; p.ge = -1; end
				19: begin p.gn = -7; p.ge = 0; p.ch = 16'h8000; end
				20: begin p.cn = 32'h7FFF_FFFF; p.gn = 32'h8000_0000; end
				default: begin p.ge = 32'h7FFF_FFFF; p.gn = 32'h8000_0000; end
			endcase
			send_pose(p);
		end
	endtask

	// Extremes of the register file, including garbage in unused data bits.
	task automatic test_register_extremes();
		set_all(0, 0, 0, 0, 0, 0);
		repeat (40) send_pose(random_pose());
		set_all(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		repeat (40) send_pose(random_pose());
		set_all(20'd1, 20'd1, 20'd65535, 20'd0, 20'd0, 20'd1);
		repeat (40) send_pose(random_pose());
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 0)
				set_all(20'(wpg_pkg::RST_MAX_ANGLE_ERROR), 410, 500, 1000, 1000, 500);
			else
				set_all(20'($urandom_range(32767)), 20'($urandom),
				        20'($urandom_range(3000)), 20'($urandom_range(3000)),
				        20'($urandom_range(3000)), 20'($urandom_range(3000)));
			steady = (ph == 2);
			repeat (230) send_pose(random_pose());
			steady = 1'b0;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random();
		wait_idle();
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d poses over 8 register settings, checked %0d commands",
		         n_sent, n_seen);
		$display("%0d commands flagged arrival", n_arrived);
		if (errors == 0 && pending_cmds.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/wpg_pkg.sv
design/wpg_cordic_stage.sv
design/wpg_div_stage.sv
design/waypoint_goto_guidance_top.sv
tb/tb_top.sv
